### rtl/clwf_pkg.sv
package clwf_pkg;

  localparam int unsigned MaxDigitsDefault = 10;
  localparam int unsigned ValueW           = 32;
  localparam int unsigned PcW              = 4;

  typedef struct packed {
    logic [2:0]        command;
    logic [1:0]        row;
    logic [5:0]        col;
    logic [ValueW-1:0] value;
    logic [3:0]        digit_count;
  } req_t;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       is_data;
    logic       last;
  } res_t;

  localparam logic [2:0] CmdRawCmd  = 3'd0;
  localparam logic [2:0] CmdRawData = 3'd1;
  localparam logic [2:0] CmdChar    = 3'd2;
  localparam logic [2:0] CmdNumber  = 3'd3;
  localparam logic [2:0] CmdInit    = 3'd4;

  localparam logic [7:0] LcdFuncSet   = 8'h38;
  localparam logic [7:0] LcdDispOn    = 8'h0C;
  localparam logic [7:0] LcdEntryMode = 8'h06;
  localparam logic [7:0] LcdClear     = 8'h01;
  localparam logic [7:0] LcdSetAddr   = 8'h80;
  localparam logic [7:0] LcdLine2Ofs  = 8'h40;
  localparam logic [7:0] AsciiZero    = 8'h30;
  localparam logic [1:0] RowSecond    = 2'd2;

  typedef enum logic [1:0] {SrcValue, SrcAddr, SrcConst, SrcDigit} src_e;
  typedef enum logic [1:0] {LastNo, LastYes, LastCntZero, LastIdxOne} last_e;
  typedef enum logic [2:0] {OpNext, OpEnd, OpEndIfCntZero, OpLoopConv, OpLoopDigit} op_e;

  typedef struct packed {
    logic       emit;
    src_e       src;
    logic       is_data;
    last_e      last;
    op_e        op;
    logic [7:0] konst;
  } uword_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } bcd_ctrl_t;

  localparam logic [PcW-1:0] PcRawCmd  = 4'd0;
  localparam logic [PcW-1:0] PcRawData = 4'd1;
  localparam logic [PcW-1:0] PcChar    = 4'd2;
  localparam logic [PcW-1:0] PcNumber  = 4'd4;
  localparam logic [PcW-1:0] PcInit    = 4'd7;

  function automatic uword_t ucode(logic [PcW-1:0] pc);
    uword_t w;
    case (pc)
      4'd0:    w = '{1'b1, SrcValue, 1'b0, LastYes,     OpEnd,          8'h00};
      4'd1:    w = '{1'b1, SrcValue, 1'b1, LastYes,     OpEnd,          8'h00};
      4'd2:    w = '{1'b1, SrcAddr,  1'b0, LastNo,      OpNext,         8'h00};
      4'd3:    w = '{1'b1, SrcValue, 1'b1, LastYes,     OpEnd,          8'h00};
      4'd4:    w = '{1'b1, SrcAddr,  1'b0, LastCntZero, OpEndIfCntZero, 8'h00};
      4'd5:    w = '{1'b0, SrcConst, 1'b0, LastNo,      OpLoopConv,     8'h00};
      4'd6:    w = '{1'b1, SrcDigit, 1'b1, LastIdxOne,  OpLoopDigit,    8'h00};
      4'd7:    w = '{1'b1, SrcConst, 1'b0, LastNo,      OpNext,         LcdFuncSet};
      4'd8:    w = '{1'b1, SrcConst, 1'b0, LastNo,      OpNext,         LcdDispOn};
      4'd9:    w = '{1'b1, SrcConst, 1'b0, LastNo,      OpNext,         LcdEntryMode};
      4'd10:   w = '{1'b1, SrcConst, 1'b0, LastNo,      OpNext,         LcdClear};
      4'd11:   w = '{1'b1, SrcConst, 1'b0, LastYes,     OpEnd,          LcdSetAddr};
      default: w = '{1'b0, SrcConst, 1'b0, LastNo,      OpEnd,          8'h00};
    endcase
    return w;
  endfunction

  function automatic logic [PcW-1:0] entry_pc(logic [2:0] cmd);
    logic [PcW-1:0] pc;
    case (cmd)
      CmdRawCmd:  pc = PcRawCmd;
      CmdRawData: pc = PcRawData;
      CmdChar:    pc = PcChar;
      CmdNumber:  pc = PcNumber;
      CmdInit:    pc = PcInit;
      default:    pc = PcRawCmd;
    endcase
    return pc;
  endfunction

endpackage

### rtl/clwf_bcd.sv
module clwf_bcd #(
  parameter int unsigned MAX_DIGITS = clwf_pkg::MaxDigitsDefault,
  parameter int unsigned DIG_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
  input  logic                        clk_i,
  input  clwf_pkg::bcd_ctrl_t         ctrl_i,
  input  logic [clwf_pkg::ValueW-1:0] value_i,
  input  logic [DIG_W-1:0]            sel_i,
  output logic [3:0]                  digit_o
);
  import clwf_pkg::*;

  // shift-add-3 conversion; digits above MAX_DIGITS are dropped (value mod 10^N)
  logic [ValueW-1:0] val_q;
  logic [3:0]        bcd_q [MAX_DIGITS];
  logic [3:0]        adj   [MAX_DIGITS];

  always_comb begin
    for (int k = 0; k < MAX_DIGITS; k++) begin
      adj[k] = (bcd_q[k] >= 4'd5) ? bcd_q[k] + 4'd3 : bcd_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) begin
      val_q <= value_i;
      for (int k = 0; k < MAX_DIGITS; k++) begin
        bcd_q[k] <= 4'd0;
      end
    end else if (ctrl_i.shift) begin
      val_q <= {val_q[ValueW-2:0], 1'b0};
      bcd_q[0] <= {adj[0][2:0], val_q[ValueW-1]};
      for (int k = 1; k < MAX_DIGITS; k++) begin
        bcd_q[k] <= {adj[k][2:0], adj[k-1][3]};
      end
    end
  end

  assign digit_o = bcd_q[sel_i];

endmodule

### rtl/char_lcd_write_formatter.sv
// The first write strobe rises on the edge after the accepting edge; one write per strobe.
// Writes per request: raw the byte, char the address then the byte, init five commands, number
// the address, a BCD conversion, then n digits (n is digit_count saturated at MAX_DIGITS).
// Codes 5 to 7 are dropped. A new request is taken at the earliest on the edge after busy falls.
// The receiver cannot stall. Reset (async, active low) clears busy, the step counter and strobe.
module char_lcd_write_formatter #(
  parameter int unsigned MAX_DIGITS = clwf_pkg::MaxDigitsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  clwf_pkg::req_t req_i,
  output logic           busy_o,
  output logic           res_valid_o,
  output clwf_pkg::res_t res_o
);
  import clwf_pkg::*;

  localparam int unsigned DigW   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [3:0]  MaxCnt = 4'(MAX_DIGITS);
  localparam logic [4:0]  ConvSteps = 5'(ValueW - 1);

  logic           busy_q, busy_d;
  logic [PcW-1:0] pc_q, pc_d;
  logic [4:0]     conv_q, conv_d;
  logic [3:0]     cnt_q, idx_q, idx_d;
  logic [7:0]     byte_q, addr_q;
  logic           res_valid_q, res_valid_d;
  res_t           res_q, res_d;

  logic       accept;
  uword_t     uw;
  bcd_ctrl_t  bcd_ctrl;
  logic [3:0] digit, sat_cnt, idx_m1;
  logic [7:0] addr_calc;

  assign accept = start_i && !busy_q && (req_i.command inside {[CmdRawCmd:CmdInit]});
  assign uw     = ucode(pc_q);
  assign sat_cnt = (req_i.digit_count > MaxCnt) ? MaxCnt : req_i.digit_count;
  assign idx_m1  = idx_q - 4'd1;
  assign addr_calc = LcdSetAddr + {2'b00, req_i.col} - 8'd1 +
                     ((req_i.row == RowSecond) ? LcdLine2Ofs : 8'h00);

  assign bcd_ctrl.clear = accept;
  assign bcd_ctrl.shift = busy_q && (uw.op == OpLoopConv);

  clwf_bcd #(
    .MAX_DIGITS(MAX_DIGITS),
    .DIG_W     (DigW)
  ) u_bcd (
    .clk_i  (clk_i),
    .ctrl_i (bcd_ctrl),
    .value_i(req_i.value),
    .sel_i  (idx_m1[DigW-1:0]),
    .digit_o(digit)
  );

  always_comb begin
    busy_d      = busy_q;
    pc_d        = pc_q;
    conv_d      = conv_q;
    idx_d       = idx_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    if (accept) begin
      busy_d = 1'b1;
      pc_d   = entry_pc(req_i.command);
      conv_d = ConvSteps;
      idx_d  = sat_cnt;
    end else if (busy_q) begin
      res_valid_d   = uw.emit;
      res_d.is_data = uw.is_data;
      case (uw.src)
        SrcValue: res_d.bus_byte = byte_q;
        SrcAddr:  res_d.bus_byte = addr_q;
        SrcDigit: res_d.bus_byte = AsciiZero + {4'b0000, digit};
        default:  res_d.bus_byte = uw.konst;
      endcase
      case (uw.last)
        LastYes:     res_d.last = 1'b1;
        LastCntZero: res_d.last = (cnt_q == 4'd0);
        LastIdxOne:  res_d.last = (idx_q == 4'd1);
        default:     res_d.last = 1'b0;
      endcase
      case (uw.op)
        OpNext: pc_d = pc_q + 4'd1;
        OpEnd:  busy_d = 1'b0;
        OpEndIfCntZero: begin
          if (cnt_q == 4'd0) begin
            busy_d = 1'b0;
          end else begin
            pc_d = pc_q + 4'd1;
          end
        end
        OpLoopConv: begin
          if (conv_q == 5'd0) begin
            pc_d = pc_q + 4'd1;
          end else begin
            conv_d = conv_q - 5'd1;
          end
        end
        OpLoopDigit: begin
          if (idx_q == 4'd1) begin
            busy_d = 1'b0;
          end else begin
            idx_d = idx_m1;
          end
        end
        default: busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    conv_q <= conv_d;
    idx_q  <= idx_d;
    res_q  <= res_d;
    if (accept) begin
      cnt_q  <= sat_cnt;
      byte_q <= req_i.value[7:0];
      addr_q <= addr_calc;
    end
  end

  assign busy_o      = busy_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import clwf_pkg::*;

  localparam int unsigned MaxDigits = MaxDigitsDefault;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 64;

  typedef struct {
    req_t rq;
    int unsigned gap;
    bit drain;
  } lcd_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t req_i = '0;
  logic busy_o;
  logic res_valid_o;
  res_t res_o;

  lcd_req_t req_queue[$];
  res_t lcd_writes_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned gap_cnt = 0;
  int unsigned cycle_cnt = 0;

  char_lcd_write_formatter #(
    .MAX_DIGITS(MaxDigits)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic void add_write(logic [7:0] b, logic d, logic l);
    lcd_writes_q.push_back(res_t'{bus_byte: b, is_data: d, last: l});
  endfunction

  // Expected display writes for one accepted request.
  function automatic void format_writes(req_t rq);
    logic [7:0] addr;
    logic [7:0] init_seq [5];
    logic [3:0] dig [10];
    logic [31:0] v;
    int unsigned cnt;
    int j;
    init_seq = '{LcdFuncSet, LcdDispOn, LcdEntryMode, LcdClear, LcdSetAddr};
    addr = LcdSetAddr + {2'b00, rq.col} - 8'd1;
    if (rq.row == RowSecond) begin
      addr = addr + LcdLine2Ofs;
    end
    case (rq.command)
      CmdRawCmd: begin
        add_write(rq.value[7:0], 1'b0, 1'b1);
      end
      CmdRawData: begin
        add_write(rq.value[7:0], 1'b1, 1'b1);
      end
      CmdChar: begin
        add_write(addr, 1'b0, 1'b0);
        add_write(rq.value[7:0], 1'b1, 1'b1);
      end
      CmdNumber: begin
        cnt = (rq.digit_count > MaxDigits) ? MaxDigits : rq.digit_count;
        v = rq.value;
        for (j = 0; j < 10; j++) begin
          dig[j] = 4'(v % 10);
          v = v / 10;
        end
        add_write(addr, 1'b0, cnt == 0);
        for (j = cnt; j > 0; j--) begin
          add_write(AsciiZero + {4'b0000, dig[j-1]}, 1'b1, j == 1);
        end
      end
      CmdInit: begin
        for (j = 0; j < 5; j++) begin
          add_write(init_seq[j], 1'b0, j == 4);
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic req_t mk_req(logic [2:0] cmd, logic [1:0] row, logic [5:0] col,
                                  logic [31:0] value, logic [3:0] cnt);
    req_t rq;
    rq.command = cmd;
    rq.row = row;
    rq.col = col;
    rq.value = value;
    rq.digit_count = cnt;
    return rq;
  endfunction

  // Driver: a request is taken on an edge with start high and busy low.
  always @(posedge clk_i) begin
    logic taken;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      taken = start_i && (busy_o === 1'b0);
      if (taken) begin
        format_writes(req_i);
      end
      if (!start_i || taken) begin
        if (req_queue.size() == 0) begin
          start_i <= 1'b0;
        end else if (gap_cnt < req_queue[0].gap ||
                     (req_queue[0].drain && lcd_writes_q.size() != 0)) begin
          gap_cnt++;
          start_i <= 1'b0;
        end else begin
          req_i <= req_queue[0].rq;
          start_i <= 1'b1;
          void'(req_queue.pop_front());
          gap_cnt = 0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    res_t exp_w;
    if (rst_ni) begin
      if (res_valid_o !== 1'b0 && res_valid_o !== 1'b1) begin
        $display("%0t: write strobe unknown: expected 0 or 1, got %b", $time, res_valid_o);
        mismatch_cnt++;
      end else if (res_valid_o) begin
        if (lcd_writes_q.size() == 0) begin
          $display("%0t: unexpected write: expected none, got byte %02h data %0b last %0b",
                   $time, res_o.bus_byte, res_o.is_data, res_o.last);
          mismatch_cnt++;
        end else begin
          exp_w = lcd_writes_q.pop_front();
          if (res_o.bus_byte !== exp_w.bus_byte || res_o.is_data !== exp_w.is_data ||
              res_o.last !== exp_w.last) begin
            $display("%0t: write mismatch: expected byte %02h data %0b last %0b,",
                     $time, exp_w.bus_byte, exp_w.is_data, exp_w.last,
                     " got byte %02h data %0b last %0b",
                     res_o.bus_byte, res_o.is_data, res_o.last);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("char_lcd_write_formatter test failed");
      $finish;
    end
  end

  initial begin
    req_t directed [$];
    lcd_req_t item;
    logic [31:0] v;
    logic [3:0] cnt;
    logic [2:0] cmd;
    logic [1:0] row;
    logic [5:0] col;
    int unsigned sel;
    int unsigned k;
    int unsigned n;
    bit burst;

    directed.push_back(mk_req(CmdInit, 2'd1, 6'd1, 32'h0, 4'd0));
    directed.push_back(mk_req(CmdRawCmd, 2'd0, 6'd0, 32'h0000_0000, 4'd0));
    directed.push_back(mk_req(CmdRawCmd, 2'd3, 6'd63, 32'hFFFF_FFFF, 4'd15));
    directed.push_back(mk_req(CmdRawData, 2'd1, 6'd1, 32'hA5A5_5AFF, 4'd0));
    directed.push_back(mk_req(CmdRawData, 2'd2, 6'd40, 32'h0000_0000, 4'd10));
    directed.push_back(mk_req(CmdChar, 2'd1, 6'd1, 32'h0000_0041, 4'd0));
    directed.push_back(mk_req(CmdChar, 2'd2, 6'd40, 32'hFFFF_FF7E, 4'd0));
    // column zero wraps below the line base
    directed.push_back(mk_req(CmdChar, 2'd1, 6'd0, 32'h0000_0030, 4'd0));
    directed.push_back(mk_req(CmdChar, 2'd2, 6'd63, 32'h0000_00FF, 4'd0));
    // rows other than two fall back to the first line
    directed.push_back(mk_req(CmdChar, 2'd0, 6'd5, 32'h0000_0020, 4'd0));
    directed.push_back(mk_req(CmdChar, 2'd3, 6'd5, 32'h0000_0000, 4'd0));
    directed.push_back(mk_req(CmdNumber, 2'd1, 6'd1, 32'd0, 4'd0));
    directed.push_back(mk_req(CmdNumber, 2'd2, 6'd1, 32'hFFFF_FFFF, 4'd10));
    directed.push_back(mk_req(CmdNumber, 2'd1, 6'd16, 32'hFFFF_FFFF, 4'd15));
    directed.push_back(mk_req(CmdNumber, 2'd2, 6'd3, 32'd123456, 4'd3));
    directed.push_back(mk_req(CmdNumber, 2'd1, 6'd0, 32'd9, 4'd1));
    directed.push_back(mk_req(CmdNumber, 2'd3, 6'd40, 32'd1000000000, 4'd11));
    directed.push_back(mk_req(CmdNumber, 2'd0, 6'd63, 32'd999999999, 4'd9));
    directed.push_back(mk_req(CmdNumber, 2'd2, 6'd20, 32'd7, 4'd12));
    directed.push_back(mk_req(CmdInit + 3'd1, 2'd1, 6'd1, 32'h41, 4'd3));
    directed.push_back(mk_req(CmdInit + 3'd2, 2'd2, 6'd2, 32'h42, 4'd3));
    directed.push_back(mk_req(CmdInit + 3'd3, 2'd3, 6'd3, 32'h43, 4'd3));
    directed.push_back(mk_req(CmdInit, 2'd2, 6'd40, 32'hFFFF_FFFF, 4'd15));

    foreach (directed[i]) begin
      item.rq = directed[i];
      item.gap = $urandom_range(0, 18);
      item.drain = (i == 12);
      req_queue.push_back(item);
    end

    burst = 1'b0;
    for (n = 0; n < 257; n++) begin
      sel = $urandom_range(0, 19);
      if (sel < 3) cmd = CmdRawCmd;
      else if (sel < 6) cmd = CmdRawData;
      else if (sel < 10) cmd = CmdChar;
      else if (sel < 16) cmd = CmdNumber;
      else if (sel < 18) cmd = CmdInit;
      else cmd = CmdInit + 3'($urandom_range(1, 3));

      row = ($urandom_range(0, 3) == 0) ? 2'($urandom) : 2'($urandom_range(1, 2));
      col = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(1, 40));

      case ($urandom_range(0, 4))
        0: v = $urandom_range(0, 999);
        1: begin
          v = 32'd1;
          for (k = $urandom_range(0, 9); k > 0; k--) v = v * 10;
          if ($urandom_range(0, 1) == 1) v = v - 1;
        end
        2: v = 32'hFFFF_FFFF - $urandom_range(0, 3);
        default: v = $urandom;
      endcase

      if ($urandom_range(0, 3) == 0) cnt = 4'($urandom_range(11, 15));
      else cnt = 4'($urandom_range(0, 10));

      if ($urandom_range(0, 15) == 0) burst = !burst;
      item.rq = mk_req(cmd, row, col, v, cnt);
      item.gap = burst ? 0 : $urandom_range(0, 18);
      item.drain = (n % 45 == 44);
      req_queue.push_back(item);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_queue.size() != 0 || start_i || lcd_writes_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("char_lcd_write_formatter test passed");
    end else begin
      $display("char_lcd_write_formatter test failed");
    end
    $finish;
  end

endmodule
